// ----- sv/cyclotomic_omega_ring_alu_assert.svh -----
// assertion macros for the omega ring alu
// no dependencies; included by the top level, the only file that checks its own logic
`ifndef CYCLOTOMIC_OMEGA_RING_ALU_ASSERT_SVH
`define CYCLOTOMIC_OMEGA_RING_ALU_ASSERT_SVH

// same-cycle implication
`define CORA_ASSERT_IMPLIES(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("implication violated");

// implication with a fixed delay in cycles
`define CORA_ASSERT_LATENCY(label, clock, reset, ante, n, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##n (cons)) \
    else $error("latency violated");

`endif

// ----- sv/cora_pkg.sv -----
// shared types and codes for the omega ring alu
// no dependencies
`default_nettype none

package cora_pkg;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_MUL = 1'b1
  } cora_op_t;

  // control that travels beside the datapath stages
  typedef struct packed {
    logic     valid;
    cora_op_t op;
  } cora_ctl_t;

  localparam int unsigned NUM_COEF = 4;
  localparam int unsigned PIPE_DEPTH = 3;

endpackage

`default_nettype wire

// ----- sv/cora_mul.sv -----
// multiply datapath: exponent sum and ring product reduced by w^4 = -1
// three register stages; depends on cora_pkg
`default_nettype none

module cora_mul #(
  parameter int unsigned COEF_BITS = 64,
  parameter int unsigned EXP_BITS  = 16
) (
  input  wire logic                 clk,
  input  wire logic [EXP_BITS-1:0]  x_exp,
  input  wire logic [EXP_BITS-1:0]  y_exp,
  input  wire logic [COEF_BITS-1:0] x_coef [cora_pkg::NUM_COEF],
  input  wire logic [COEF_BITS-1:0] y_coef [cora_pkg::NUM_COEF],
  output logic      [EXP_BITS-1:0]  res_exp,
  output logic      [COEF_BITS-1:0] res_coef [cora_pkg::NUM_COEF],
  output logic                      res_ovf
);

  localparam int unsigned LB = (COEF_BITS + 1) / 2;
  localparam int unsigned HB = COEF_BITS - LB;

  logic [2*LB-1:0]    ll_c [4][4];
  logic [HB-1:0]      lh_c [4][4];
  logic [HB-1:0]      hl_c [4][4];
  logic [COEF_BITS-1:0] lh_full [4][4];
  logic [COEF_BITS-1:0] hl_full [4][4];
  logic [2*LB-1:0]    ll1 [4][4];
  logic [HB-1:0]      lh1 [4][4];
  logic [HB-1:0]      hl1 [4][4];
  logic [COEF_BITS-1:0] prod_c [4][4];
  logic [COEF_BITS-1:0] prod2 [4][4];
  logic [COEF_BITS-1:0] acc_c [cora_pkg::NUM_COEF];
  logic [EXP_BITS:0]  exp_sum;
  logic [EXP_BITS-1:0] exp1, exp2;
  logic               ovf1, ovf2;

  // stage 1: 32x32 partial products, only the low cross bits are kept
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        ll_c[i][j]    = x_coef[i][LB-1:0] * y_coef[j][LB-1:0];
        lh_full[i][j] = x_coef[i][LB-1:0] * y_coef[j][COEF_BITS-1:LB];
        hl_full[i][j] = x_coef[i][COEF_BITS-1:LB] * y_coef[j][LB-1:0];
        lh_c[i][j]    = lh_full[i][j][HB-1:0];
        hl_c[i][j]    = hl_full[i][j][HB-1:0];
      end
    end
  end

  assign exp_sum = {x_exp[EXP_BITS-1], x_exp} + {y_exp[EXP_BITS-1], y_exp};

  always_ff @(posedge clk) begin
    ll1  <= ll_c;
    lh1  <= lh_c;
    hl1  <= hl_c;
    exp1 <= exp_sum[EXP_BITS-1:0];
    ovf1 <= exp_sum[EXP_BITS] ^ exp_sum[EXP_BITS-1];
  end

  // stage 2: assemble the sixteen wrapped products
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_c[i][j] = ll1[i][j][COEF_BITS-1:0]
                     + {lh1[i][j] + hl1[i][j], {LB{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    prod2 <= prod_c;
    exp2  <= exp1;
    ovf2  <= ovf1;
  end

  // stage 3: fold degrees, terms past w^3 come back negated
  always_comb begin
    logic [1:0] r;
    r = '0;
    for (int k = 0; k < 4; k++) acc_c[k] = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        r = 2'(i + j + 1);
        if (i + j <= 2) begin
          acc_c[r] = acc_c[r] - prod2[i][j];
        end else begin
          acc_c[r] = acc_c[r] + prod2[i][j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    res_coef <= acc_c;
    res_exp  <= exp2;
    res_ovf  <= ovf2;
  end

endmodule

`default_nettype wire

// ----- sv/cora_align.sv -----
// add datapath: parity fix by sqrt2, alignment shift, coefficient sum
// three register stages; depends on cora_pkg
`default_nettype none

module cora_align #(
  parameter int unsigned COEF_BITS = 64,
  parameter int unsigned EXP_BITS  = 16
) (
  input  wire logic                 clk,
  input  wire logic [EXP_BITS-1:0]  x_exp,
  input  wire logic [EXP_BITS-1:0]  y_exp,
  input  wire logic [COEF_BITS-1:0] x_coef [cora_pkg::NUM_COEF],
  input  wire logic [COEF_BITS-1:0] y_coef [cora_pkg::NUM_COEF],
  output logic      [EXP_BITS-1:0]  res_exp,
  output logic      [COEF_BITS-1:0] res_coef [cora_pkg::NUM_COEF],
  output logic                      res_ovf
);

  localparam int unsigned SHW = EXP_BITS + 1;
  localparam int unsigned SB  = $clog2(COEF_BITS);
  localparam logic [SHW-1:0] COEF_LIM = SHW'(COEF_BITS);
  localparam logic [EXP_BITS-1:0] EXP_MAXPOS = {1'b0, {(EXP_BITS-1){1'b1}}};

  logic                 rx, ry, x_ge, hi_raised;
  logic [COEF_BITS-1:0] xs [cora_pkg::NUM_COEF];
  logic [COEF_BITS-1:0] ys [cora_pkg::NUM_COEF];
  logic [COEF_BITS-1:0] xe [cora_pkg::NUM_COEF];
  logic [COEF_BITS-1:0] ye [cora_pkg::NUM_COEF];
  logic [SHW-1:0]       hx, hy, shift_full;
  logic [EXP_BITS-1:0]  hi_k;

  logic [COEF_BITS-1:0] hi1 [cora_pkg::NUM_COEF];
  logic [COEF_BITS-1:0] lo1 [cora_pkg::NUM_COEF];
  logic [SB-1:0]        sh1;
  logic                 big1, ovf1, ovf2;
  logic [EXP_BITS-1:0]  exp1, exp2;
  logic [COEF_BITS-1:0] hi2 [cora_pkg::NUM_COEF];
  logic [COEF_BITS-1:0] los2 [cora_pkg::NUM_COEF];

  // only the odd operand is raised, and only when parities differ
  assign rx = (x_exp[0] ^ y_exp[0]) & x_exp[0];
  assign ry = (x_exp[0] ^ y_exp[0]) & y_exp[0];

  // times sqrt2: (a,b,c,d) -> (b-d, c+a, b+d, c-a)
  assign xs[0] = x_coef[1] - x_coef[3];
  assign xs[1] = x_coef[2] + x_coef[0];
  assign xs[2] = x_coef[1] + x_coef[3];
  assign xs[3] = x_coef[2] - x_coef[0];
  assign ys[0] = y_coef[1] - y_coef[3];
  assign ys[1] = y_coef[2] + y_coef[0];
  assign ys[2] = y_coef[1] + y_coef[3];
  assign ys[3] = y_coef[2] - y_coef[0];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      xe[i] = rx ? xs[i] : x_coef[i];
      ye[i] = ry ? ys[i] : y_coef[i];
    end
  end

  // floor half of the exponent, plus one if raised
  assign hx = {x_exp[EXP_BITS-1], x_exp[EXP_BITS-1], x_exp[EXP_BITS-1:1]}
            + {{EXP_BITS{1'b0}}, rx};
  assign hy = {y_exp[EXP_BITS-1], y_exp[EXP_BITS-1], y_exp[EXP_BITS-1:1]}
            + {{EXP_BITS{1'b0}}, ry};
  assign x_ge       = $signed(hx) >= $signed(hy);
  assign shift_full = x_ge ? (hx - hy) : (hy - hx);
  assign hi_k       = x_ge ? x_exp : y_exp;
  assign hi_raised  = x_ge ? rx : ry;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      hi1[i] <= x_ge ? xe[i] : ye[i];
      lo1[i] <= x_ge ? ye[i] : xe[i];
    end
    sh1  <= shift_full[SB-1:0];
    big1 <= shift_full >= COEF_LIM;
    exp1 <= hi_k + {{(EXP_BITS-1){1'b0}}, hi_raised};
    ovf1 <= hi_raised && (hi_k == EXP_MAXPOS);
  end

  // stage 2: scale the lower operand, whole word shifted out gives zero
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      hi2[i]  <= hi1[i];
      los2[i] <= big1 ? '0 : (lo1[i] << sh1);
    end
    exp2 <= exp1;
    ovf2 <= ovf1;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      res_coef[i] <= hi2[i] + los2[i];
    end
    res_exp <= exp2;
    res_ovf <= ovf2;
  end

endmodule

`default_nettype wire

// ----- sv/cyclotomic_omega_ring_alu.sv -----
// top level of the omega ring alu: request port, control pipe, result select
// depends on cora_pkg, cora_mul, cora_align and the assertion header
//
//   channel   handshake          payload
//   request   start / busy       operation, x_*, y_*
//   result    done (one cycle)   res_exponent, res_coef_w*, exponent_overflow
//
// a request is taken in every cycle; busy stays low
// each result passes through the three register stages of the multiply
// path (partial products, assembly, fold) or of the add path
// rst is synchronous and clears only the control pipe, valid and op bits alike
// the receiver cannot stall, so nothing is ever held back
`default_nettype none

`include "cyclotomic_omega_ring_alu_assert.svh"

module cyclotomic_omega_ring_alu #(
  parameter int unsigned COEF_BITS = 64,
  parameter int unsigned EXP_BITS  = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        operation,
  input  wire logic signed [EXP_BITS-1:0]  x_exponent,
  input  wire logic signed [COEF_BITS-1:0] x_coef_w3,
  input  wire logic signed [COEF_BITS-1:0] x_coef_w2,
  input  wire logic signed [COEF_BITS-1:0] x_coef_w1,
  input  wire logic signed [COEF_BITS-1:0] x_coef_w0,
  input  wire logic signed [EXP_BITS-1:0]  y_exponent,
  input  wire logic signed [COEF_BITS-1:0] y_coef_w3,
  input  wire logic signed [COEF_BITS-1:0] y_coef_w2,
  input  wire logic signed [COEF_BITS-1:0] y_coef_w1,
  input  wire logic signed [COEF_BITS-1:0] y_coef_w0,
  output logic                             done,
  output logic signed [EXP_BITS-1:0]       res_exponent,
  output logic signed [COEF_BITS-1:0]      res_coef_w3,
  output logic signed [COEF_BITS-1:0]      res_coef_w2,
  output logic signed [COEF_BITS-1:0]      res_coef_w1,
  output logic signed [COEF_BITS-1:0]      res_coef_w0,
  output logic                             exponent_overflow
);

  localparam logic [EXP_BITS-1:0] EXP_MIN = {1'b1, {(EXP_BITS-1){1'b0}}};

  logic [COEF_BITS-1:0] x_coef [cora_pkg::NUM_COEF];
  logic [COEF_BITS-1:0] y_coef [cora_pkg::NUM_COEF];
  logic [COEF_BITS-1:0] mul_coef [cora_pkg::NUM_COEF];
  logic [COEF_BITS-1:0] add_coef [cora_pkg::NUM_COEF];
  logic [EXP_BITS-1:0]  mul_exp, add_exp;
  logic                 mul_ovf, add_ovf;
  logic                 accept;

  cora_pkg::cora_ctl_t ctl_in;
  cora_pkg::cora_ctl_t ctl [cora_pkg::PIPE_DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign x_coef[0] = x_coef_w3;
  assign x_coef[1] = x_coef_w2;
  assign x_coef[2] = x_coef_w1;
  assign x_coef[3] = x_coef_w0;
  assign y_coef[0] = y_coef_w3;
  assign y_coef[1] = y_coef_w2;
  assign y_coef[2] = y_coef_w1;
  assign y_coef[3] = y_coef_w0;

  cora_mul #(
    .COEF_BITS (COEF_BITS),
    .EXP_BITS  (EXP_BITS)
  ) u_mul (
    .clk      (clk),
    .x_exp    (x_exponent),
    .y_exp    (y_exponent),
    .x_coef   (x_coef),
    .y_coef   (y_coef),
    .res_exp  (mul_exp),
    .res_coef (mul_coef),
    .res_ovf  (mul_ovf)
  );

  cora_align #(
    .COEF_BITS (COEF_BITS),
    .EXP_BITS  (EXP_BITS)
  ) u_align (
    .clk      (clk),
    .x_exp    (x_exponent),
    .y_exp    (y_exponent),
    .x_coef   (x_coef),
    .y_coef   (y_coef),
    .res_exp  (add_exp),
    .res_coef (add_coef),
    .res_ovf  (add_ovf)
  );

  assign ctl_in.valid = accept;
  assign ctl_in.op    = cora_pkg::cora_op_t'(operation);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < cora_pkg::PIPE_DEPTH; s++) begin
        ctl[s] <= '0;
      end
    end else begin
      ctl[0] <= ctl_in;
      for (int s = 1; s < cora_pkg::PIPE_DEPTH; s++) begin
        ctl[s] <= ctl[s-1];
      end
    end
  end

  assign done = ctl[cora_pkg::PIPE_DEPTH-1].valid;

  always_comb begin
    case (ctl[cora_pkg::PIPE_DEPTH-1].op)
      cora_pkg::OP_MUL: begin
        res_exponent      = mul_exp;
        res_coef_w3       = mul_coef[0];
        res_coef_w2       = mul_coef[1];
        res_coef_w1       = mul_coef[2];
        res_coef_w0       = mul_coef[3];
        exponent_overflow = mul_ovf;
      end
      default: begin
        res_exponent      = add_exp;
        res_coef_w3       = add_coef[0];
        res_coef_w2       = add_coef[1];
        res_coef_w1       = add_coef[2];
        res_coef_w0       = add_coef[3];
        exponent_overflow = add_ovf;
      end
    endcase
  end

  `CORA_ASSERT_LATENCY(a_request_latency, clk, rst, accept, 3, done)
  `CORA_ASSERT_IMPLIES(a_done_has_request, clk, rst, done, $past(accept, 3))
  `CORA_ASSERT_IMPLIES(a_add_ovf_wraps_to_min, clk, rst,
    done && exponent_overflow && (ctl[cora_pkg::PIPE_DEPTH-1].op == cora_pkg::OP_ADD),
    res_exponent == EXP_MIN)
  `CORA_ASSERT_IMPLIES(a_mul_ovf_flips_sign, clk, rst,
    done && exponent_overflow && (ctl[cora_pkg::PIPE_DEPTH-1].op == cora_pkg::OP_MUL),
    res_exponent[EXP_BITS-1] != $past(x_exponent[EXP_BITS-1], 3))

endmodule

`default_nettype wire

// ----- tb/sv/ring_alu_checker.sv -----
// result checker for the omega ring alu: predicts each request and compares results in order
// depends on cora_pkg; instantiated by tb_top beside the block
module ring_alu_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        operation,
  input  logic [15:0] x_exponent,
  input  logic [63:0] x_coef_w3,
  input  logic [63:0] x_coef_w2,
  input  logic [63:0] x_coef_w1,
  input  logic [63:0] x_coef_w0,
  input  logic [15:0] y_exponent,
  input  logic [63:0] y_coef_w3,
  input  logic [63:0] y_coef_w2,
  input  logic [63:0] y_coef_w1,
  input  logic [63:0] y_coef_w0,
  input  logic        done,
  input  logic [15:0] res_exponent,
  input  logic [63:0] res_coef_w3,
  input  logic [63:0] res_coef_w2,
  input  logic [63:0] res_coef_w1,
  input  logic [63:0] res_coef_w0,
  input  logic        exponent_overflow,
  output int          mismatches,
  output int          pending,
  output int          add_requests,
  output int          mul_requests,
  output int          overflow_results,
  output int          results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EXP_MAX = 32767;
  localparam int EXP_MIN = -32768;

  typedef struct packed {
    logic [15:0]      k;
    logic [3:0][63:0] coef;  // index 3 is the w^3 term
    logic             ovf;
  } ring_val_t;

  ring_val_t awaited_results[$];
  ring_val_t want;

  // multiply by sqrt2: (a,b,c,d) -> (b-d, c+a, b+d, c-a)
  function automatic logic [3:0][63:0] times_root2(input logic [3:0][63:0] c);
    logic [3:0][63:0] r;
    r[3] = c[2] - c[0];
    r[2] = c[1] + c[3];
    r[1] = c[2] + c[0];
    r[0] = c[1] - c[3];
    return r;
  endfunction

  function automatic ring_val_t omega_ring_op(input cora_pkg::cora_op_t op,
      input logic [15:0] xk_bits, input logic [3:0][63:0] xc_in,
      input logic [15:0] yk_bits, input logic [3:0][63:0] yc_in);
    ring_val_t        r;
    int               xk, yk, sum, hx, hy, shift, hi_k, rx, ry, hi_raised;
    logic [3:0][63:0] xc, yc, hi_c, lo_c;
    xk = $signed(xk_bits);
    yk = $signed(yk_bits);
    xc = xc_in;
    yc = yc_in;
    r = '0;
    if (op == cora_pkg::OP_MUL) begin
      sum = xk + yk;
      r.k = sum[15:0];
      r.ovf = (sum > EXP_MAX) || (sum < EXP_MIN);
      r.coef[3] = xc[3]*yc[0] + xc[2]*yc[1] + xc[1]*yc[2] + xc[0]*yc[3];
      r.coef[2] = xc[2]*yc[0] + xc[1]*yc[1] + xc[0]*yc[2] - xc[3]*yc[3];
      r.coef[1] = xc[1]*yc[0] + xc[0]*yc[1] - xc[3]*yc[2] - xc[2]*yc[3];
      r.coef[0] = xc[0]*yc[0] - xc[3]*yc[1] - xc[2]*yc[2] - xc[1]*yc[3];
    end else begin
      rx = 0;
      ry = 0;
      // odd operand gets the sqrt2 factor so both exponents share parity
      if (xk[0] != yk[0]) begin
        if (xk[0]) begin
          rx = 1;
          xc = times_root2(xc);
        end else begin
          ry = 1;
          yc = times_root2(yc);
        end
      end
      hx = (xk >>> 1) + rx;
      hy = (yk >>> 1) + ry;
      if (hx >= hy) begin
        hi_c = xc; lo_c = yc; shift = hx - hy; hi_k = xk; hi_raised = rx;
      end else begin
        hi_c = yc; lo_c = xc; shift = hy - hx; hi_k = yk; hi_raised = ry;
      end
      sum = hi_k + hi_raised;
      r.k = sum[15:0];
      r.ovf = (hi_raised != 0) && (hi_k == EXP_MAX);
      for (int i = 0; i < 4; i++)
        r.coef[i] = hi_c[i] + ((shift >= 64) ? 64'd0 : (lo_c[i] << shift));
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] exp_v,
      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
    add_requests = 0;
    mul_requests = 0;
    overflow_results = 0;
    results_checked = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      // results leave before requests enter, so the oldest is popped first
      if (done) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with no request outstanding, exponent %h", $time,
                   res_exponent);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("res_exponent", want.k, res_exponent);
          compare_field("res_coef_w3", want.coef[3], res_coef_w3);
          compare_field("res_coef_w2", want.coef[2], res_coef_w2);
          compare_field("res_coef_w1", want.coef[1], res_coef_w1);
          compare_field("res_coef_w0", want.coef[0], res_coef_w0);
          compare_field("exponent_overflow", want.ovf, exponent_overflow);
          results_checked++;
        end
      end
      if (start && !busy) begin
        want = omega_ring_op(cora_pkg::cora_op_t'(operation),
            x_exponent, {x_coef_w3, x_coef_w2, x_coef_w1, x_coef_w0},
            y_exponent, {y_coef_w3, y_coef_w2, y_coef_w1, y_coef_w0});
        awaited_results.push_back(want);
        if (operation == cora_pkg::OP_MUL) mul_requests++;
        else add_requests++;
        if (want.ovf) overflow_results++;
      end
    end
    pending = awaited_results.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench top for the omega ring alu: clock, reset, request stimulus and verdict
// depends on cora_pkg, cyclotomic_omega_ring_alu and ring_alu_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [63:0] C_MAX  = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] C_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] C_ONES = 64'hffff_ffff_ffff_ffff;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        operation;
  logic [15:0] x_exponent, y_exponent;
  logic [63:0] x_coef_w3, x_coef_w2, x_coef_w1, x_coef_w0;
  logic [63:0] y_coef_w3, y_coef_w2, y_coef_w1, y_coef_w0;
  logic        done;
  logic [15:0] res_exponent;
  logic [63:0] res_coef_w3, res_coef_w2, res_coef_w1, res_coef_w0;
  logic        exponent_overflow;

  int mismatches, pending, add_requests, mul_requests, overflow_results, results_checked;
  int cycles;

  cyclotomic_omega_ring_alu dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .x_exponent(x_exponent), .x_coef_w3(x_coef_w3), .x_coef_w2(x_coef_w2),
    .x_coef_w1(x_coef_w1), .x_coef_w0(x_coef_w0),
    .y_exponent(y_exponent), .y_coef_w3(y_coef_w3), .y_coef_w2(y_coef_w2),
    .y_coef_w1(y_coef_w1), .y_coef_w0(y_coef_w0),
    .done(done), .res_exponent(res_exponent), .res_coef_w3(res_coef_w3),
    .res_coef_w2(res_coef_w2), .res_coef_w1(res_coef_w1), .res_coef_w0(res_coef_w0),
    .exponent_overflow(exponent_overflow)
  );

  ring_alu_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .x_exponent(x_exponent), .x_coef_w3(x_coef_w3), .x_coef_w2(x_coef_w2),
    .x_coef_w1(x_coef_w1), .x_coef_w0(x_coef_w0),
    .y_exponent(y_exponent), .y_coef_w3(y_coef_w3), .y_coef_w2(y_coef_w2),
    .y_coef_w1(y_coef_w1), .y_coef_w0(y_coef_w0),
    .done(done), .res_exponent(res_exponent), .res_coef_w3(res_coef_w3),
    .res_coef_w2(res_coef_w2), .res_coef_w1(res_coef_w1), .res_coef_w0(res_coef_w0),
    .exponent_overflow(exponent_overflow),
    .mismatches(mismatches), .pending(pending), .add_requests(add_requests),
    .mul_requests(mul_requests), .overflow_results(overflow_results),
    .results_checked(results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycles, pending);
      $display("simulation failed");
      $finish;
    end
  end

  // hold the request until an edge finds busy low
  task automatic issue(input cora_pkg::cora_op_t op, input logic [15:0] xk,
      input logic [3:0][63:0] xc, input logic [15:0] yk, input logic [3:0][63:0] yc);
    logic stalled;
    start <= 1'b1;
    operation <= op;
    x_exponent <= xk;
    {x_coef_w3, x_coef_w2, x_coef_w1, x_coef_w0} <= xc;
    y_exponent <= yk;
    {y_coef_w3, y_coef_w2, y_coef_w1, y_coef_w0} <= yc;
    do begin
      @(negedge clk);
      stalled = busy;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_coef();
    int s;
    s = $urandom_range(0, 200) - 100;
    case ($urandom_range(0, 7))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return {{32{s[31]}}, s} >>> 0;
      3:       return {{32{s[31]}}, s};
      4:       return {$urandom, $urandom} >> $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [15:0] rand_exponent();
    int s;
    case ($urandom_range(0, 5))
      0:       s = 32767 - $urandom_range(0, 3);
      1:       s = -32768 + $urandom_range(0, 3);
      2:       s = $urandom;
      default: s = $urandom_range(0, 160) - 80;
    endcase
    return s[15:0];
  endfunction

  task automatic random_phase(input int count, input int idle_pct);
    logic [15:0]        xk, yk;
    logic [3:0][63:0]   xc, yc;
    cora_pkg::cora_op_t op;
    for (int n = 0; n < count; n++) begin
      while ($urandom_range(0, 99) < idle_pct) idle_cycle();
      op = $urandom_range(0, 1) ? cora_pkg::OP_MUL : cora_pkg::OP_ADD;
      xk = rand_exponent();
      // keep exponents close often so the alignment shift stays below the width
      yk = ($urandom_range(0, 2) == 0) ? xk + 16'($urandom_range(0, 140) - 70)
                                       : rand_exponent();
      for (int i = 0; i < 4; i++) begin
        xc[i] = rand_coef();
        yc[i] = rand_coef();
      end
      issue(op, xk, xc, yk, yc);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    operation = cora_pkg::OP_ADD;
    x_exponent = '0;
    y_exponent = '0;
    {x_coef_w3, x_coef_w2, x_coef_w1, x_coef_w0} = '0;
    {y_coef_w3, y_coef_w2, y_coef_w1, y_coef_w0} = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // equal exponents, plain sums and coefficient wrap
    issue(cora_pkg::OP_ADD, 16'd0, {64'd1, 64'd2, 64'd3, 64'd4}, 16'd0,
          {64'd5, 64'd6, 64'd7, 64'd8});
    issue(cora_pkg::OP_ADD, 16'd4, {4{C_MAX}}, 16'd4, {4{C_MAX}});
    issue(cora_pkg::OP_ADD, -16'sd6, {4{C_MIN}}, -16'sd6, {C_MIN, C_ONES, C_MIN, C_ONES});
    // products of unit terms and of full words, reduction by w^4 = -1
    issue(cora_pkg::OP_MUL, 16'd0, {64'd0, 64'd0, 64'd0, 64'd1}, 16'd5,
          {64'd9, C_MIN, C_MAX, C_ONES});
    issue(cora_pkg::OP_MUL, 16'd1, {64'd0, 64'd0, 64'd1, 64'd0}, 16'd2,
          {64'd0, 64'd0, 64'd1, 64'd0});
    issue(cora_pkg::OP_MUL, 16'd3, {64'd1, 64'd0, 64'd0, 64'd0}, -16'sd3,
          {64'd0, 64'd1, 64'd0, 64'd0});
    issue(cora_pkg::OP_MUL, 16'd0, {4{C_MAX}}, 16'd0, {4{C_MIN}});
    issue(cora_pkg::OP_MUL, 16'd0, {4{C_ONES}}, 16'd0, {C_ONES, 64'd0, C_MAX, 64'd3});
    // multiply exponent overflow both ways, by one past the top, and a near miss
    issue(cora_pkg::OP_MUL, 16'h7fff, {4{64'd1}}, 16'h7fff, {4{64'd1}});
    issue(cora_pkg::OP_MUL, 16'h8000, {4{64'd2}}, 16'h8000, {4{64'd3}});
    issue(cora_pkg::OP_MUL, 16'h8000, {4{64'd2}}, 16'h7fff, {4{64'd3}});
    issue(cora_pkg::OP_MUL, 16'h7fff, {4{64'd2}}, 16'd1, {4{64'd3}});
    // odd exponent difference, sqrt2 applied to one side or the other
    issue(cora_pkg::OP_ADD, 16'd3, {64'd1, 64'd2, 64'd3, 64'd4}, 16'd0,
          {64'd5, 64'd6, 64'd7, 64'd8});
    issue(cora_pkg::OP_ADD, 16'd2, {64'd1, 64'd2, 64'd3, 64'd4}, -16'sd1,
          {64'd5, 64'd6, 64'd7, 64'd8});
    issue(cora_pkg::OP_ADD, -16'sd1, {4{C_ONES}}, -16'sd2, {C_MAX, C_MIN, C_ONES, 64'd1});
    // raised exponent leaves the range
    issue(cora_pkg::OP_ADD, 16'h7fff, {4{64'd7}}, 16'd0, {4{64'd9}});
    issue(cora_pkg::OP_ADD, 16'd0, {4{64'd7}}, 16'h7fff, {4{64'd9}});
    issue(cora_pkg::OP_ADD, 16'h8000, {4{C_MAX}}, 16'h7fff, {4{C_MIN}});
    // alignment shifts of 62, 63, 64 and beyond
    issue(cora_pkg::OP_ADD, 16'd126, {4{64'd1}}, 16'd0, {64'd1, 64'd3, C_ONES, C_MAX});
    issue(cora_pkg::OP_ADD, 16'd128, {4{64'd1}}, 16'd0, {4{C_ONES}});
    issue(cora_pkg::OP_ADD, -16'sd126, {64'd1, 64'd2, 64'd3, C_ONES}, -16'sd2,
          {4{64'd5}});
    issue(cora_pkg::OP_ADD, 16'h7ffe, {4{64'd1}}, 16'h8000, {4{C_ONES}});
    // both odd, equal and unequal
    issue(cora_pkg::OP_ADD, 16'd5, {64'd1, 64'd2, 64'd3, 64'd4}, 16'd5,
          {64'd4, 64'd3, 64'd2, 64'd1});
    issue(cora_pkg::OP_ADD, -16'sd3, {4{64'd3}}, 16'd7, {4{64'd11}});
    drain();

    random_phase(283, 9);
    drain();
    random_phase(283, 53);
    drain();
    random_phase(284, 0);
    drain();

    repeat (cora_pkg::PIPE_DEPTH + 6) @(posedge clk);
    $display("%0d requests (%0d add, %0d multiply), %0d results compared",
             add_requests + mul_requests, add_requests, mul_requests, results_checked);
    $display("%0d results carried the exponent overflow flag, %0d mismatches",
             overflow_results, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
